>>> rtl/mpool_pkg.sv
// Shared constants, register codes and types of the max pooling with argmax block.
package mpool_pkg;

  // Sizing
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_POOL   = 4;
  localparam int VALUE_BITS = 16;
  localparam int STEP_MAX   = 7;

  localparam int LINE_ROWS = MAX_POOL - 1;
  localparam int LINE_LEN  = MAX_WIDTH + 6;
  localparam int ADDR_W    = $clog2(LINE_LEN);
  localparam int CNT_W     = $clog2(LINE_LEN + 16);
  localparam int SLOT_W    = $clog2(LINE_ROWS + 1);
  localparam int RES_W     = $clog2(STEP_MAX + 1);
  localparam int PC_W      = $clog2(MAX_POOL + 1);
  localparam int PI_W      = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
  localparam int WIN_N     = MAX_POOL * MAX_POOL;
  localparam int TREE_LVL  = $clog2(WIN_N);
  localparam int TREE_LEAF = 1 << TREE_LVL;
  localparam int PROD_W    = 2 * PC_W + 1;

  // Field and register widths
  localparam int DIM_W      = 11;
  localparam int POOL_W     = 3;
  localparam int STEP_W     = 3;
  localparam int BORDER_W   = 2;
  localparam int POS_W      = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int OUT_W      = ((VALUE_BITS + POS_W + 7) / 8) * 8;

  // Register reset values
  localparam logic [DIM_W-1:0]    RST_IN_HEIGHT = DIM_W'(8);
  localparam logic [DIM_W-1:0]    RST_IN_WIDTH  = DIM_W'(8);
  localparam logic [POOL_W-1:0]   RST_POOL_H    = POOL_W'(2);
  localparam logic [POOL_W-1:0]   RST_POOL_W    = POOL_W'(2);
  localparam logic [STEP_W-1:0]   RST_STEP      = STEP_W'(2);
  localparam logic [BORDER_W-1:0] RST_BORDER    = BORDER_W'(0);

  // Register index codes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_HEIGHT = 3'd0,
    CFG_IN_WIDTH  = 3'd1,
    CFG_POOL_H    = 3'd2,
    CFG_POOL_W    = 3'd3,
    CFG_STEP      = 3'd4,
    CFG_BORDER    = 3'd5
  } cfg_reg_e;

  // One node of the max/argmax compare tree
  typedef struct packed {
    logic                         vld;
    logic signed [VALUE_BITS-1:0] val;
    logic [PI_W-1:0]              row;
    logic [PI_W-1:0]              col;
  } tree_node_t;

endpackage

>>> rtl/max_pool_2d_argmax.sv
// Max pooling with argmax over a streamed, zero-padded channel plane.
//
//  channel | direction | payload (low bit first)                     | transfer when
//  s_axis  | in        | tdata: pixel[15:0]                          | tvalid & tready
//  m_axis  | out       | tdata: window_max[15:0], max_position[19:16] | tvalid & tready
//          |           | tlast: frame_done                           |
//  cfg     | in        | cfg_index_i, cfg_data_i                     | cfg_valid_i & cfg_ready_o
//
// One pixel per cycle once clearing is over and while the output is not stalled. A result
// passes line memory read, window shift and compare tree into the output register.
// After reset a clearing pass zeroes all LINE_LEN (1030) line memory addresses with
// s_axis_tready_o low; configuration writes are taken during it.
// A stalled output fills the window and line stages behind it, then tready drops.
module max_pool_2d_argmax
  import mpool_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // pixel stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [VALUE_BITS-1:0] s_axis_tdata_i,   // [15:0] pixel
  // result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_W-1:0]      m_axis_tdata_o,   // [15:0] window_max, [19:16] max_position
  output logic                  m_axis_tlast_o,   // frame_done
  // register writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [DIM_W-1:0]    in_height_q, in_width_q;
  logic [POOL_W-1:0]   pool_h_q, pool_w_q;
  logic [STEP_W-1:0]   step_q;
  logic [BORDER_W-1:0] border_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_height_q <= RST_IN_HEIGHT;
      in_width_q  <= RST_IN_WIDTH;
      pool_h_q    <= RST_POOL_H;
      pool_w_q    <= RST_POOL_W;
      step_q      <= RST_STEP;
      border_q    <= RST_BORDER;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_IN_HEIGHT: in_height_q <= cfg_data_i[DIM_W-1:0];
        CFG_IN_WIDTH:  in_width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_POOL_H:    pool_h_q    <= cfg_data_i[POOL_W-1:0];
        CFG_POOL_W:    pool_w_q    <= cfg_data_i[POOL_W-1:0];
        CFG_STEP:      step_q      <= cfg_data_i[STEP_W-1:0];
        CFG_BORDER:    border_q    <= cfg_data_i[BORDER_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamped sizes and padded frame bounds
  logic [CNT_W-1:0]  h_c, w_c, hp, wp, b_ext;
  logic [PC_W-1:0]   ph_c, pw_c;
  logic [STEP_W-1:0] s_c;

  always_comb begin
    if (in_height_q == '0)                    h_c = CNT_W'(1);
    else if (in_height_q > DIM_W'(MAX_WIDTH)) h_c = CNT_W'(MAX_WIDTH);
    else                                      h_c = CNT_W'(in_height_q);
    if (in_width_q == '0)                     w_c = CNT_W'(1);
    else if (in_width_q > DIM_W'(MAX_WIDTH))  w_c = CNT_W'(MAX_WIDTH);
    else                                      w_c = CNT_W'(in_width_q);
    if (pool_h_q == '0)                       ph_c = PC_W'(1);
    else if (PC_W'(pool_h_q) > PC_W'(MAX_POOL)) ph_c = PC_W'(MAX_POOL);
    else                                      ph_c = PC_W'(pool_h_q);
    if (pool_w_q == '0)                       pw_c = PC_W'(1);
    else if (PC_W'(pool_w_q) > PC_W'(MAX_POOL)) pw_c = PC_W'(MAX_POOL);
    else                                      pw_c = PC_W'(pool_w_q);
    s_c   = (step_q == '0) ? STEP_W'(1) : step_q;
    b_ext = CNT_W'(border_q);
    hp    = h_c + (b_ext << 1);
    wp    = w_c + (b_ext << 1);
  end

  // (p - 1) mod s for a pool size p and step s, by repeated subtraction
  function automatic logic [RES_W-1:0] pool_phase(input logic [PC_W-1:0]   p,
                                                  input logic [STEP_W-1:0] s);
    logic [PC_W+STEP_W-1:0] t;
    t = (PC_W+STEP_W)'(p) - (PC_W+STEP_W)'(1);
    for (int i = 0; i < MAX_POOL; i++) begin
      if (t >= (PC_W+STEP_W)'(s)) t = t - (PC_W+STEP_W)'(s);
    end
    return t[RES_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake of the stages
  logic clearing_q;
  logic s1_valid_q, emit1_q, done1_q;
  logic emit2_q, done2_q;
  logic out_valid_q;
  logic out_free, s2_fire, s1_fire, in_ready, in_fire;

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s2_fire  = emit2_q && out_free;
  assign s1_fire  = s1_valid_q && (!emit2_q || s2_fire);
  assign in_ready = !clearing_q && (!s1_valid_q || s1_fire);
  assign in_fire  = s_axis_tvalid_i && in_ready;
  assign s_axis_tready_o = in_ready;

  // ---------------------------------------------------------------------------
  // Position counters, line slot and step residues
  logic [CNT_W-1:0]  r_q, c_q, r_d, c_d;
  logic [SLOT_W-1:0] rs_q, rs_d;
  logic [RES_W-1:0]  res_r_q [1:STEP_MAX];
  logic [RES_W-1:0]  res_c_q [1:STEP_MAX];
  logic [RES_W-1:0]  res_r_d [1:STEP_MAX];
  logic [RES_W-1:0]  res_c_d [1:STEP_MAX];

  logic [CNT_W:0] r1, c1;
  logic           row_ok, col_ok, emit0, done0, in_plane;
  logic [VALUE_BITS-1:0] v0;

  always_comb begin
    r1 = {1'b0, r_q} + (CNT_W+1)'(1);
    c1 = {1'b0, c_q} + (CNT_W+1)'(1);
    // window closes on this sample in each direction
    row_ok = (r1 >= (CNT_W+1)'(ph_c)) && (r1 <= {1'b0, hp}) &&
             (res_r_q[s_c] == pool_phase(ph_c, s_c));
    col_ok = (c1 >= (CNT_W+1)'(pw_c)) && (c1 <= {1'b0, wp}) &&
             (res_c_q[s_c] == pool_phase(pw_c, s_c));
    emit0  = row_ok && col_ok;
    // last window row and column: one more step runs past the frame
    done0  = (r1 + (CNT_W+1)'(s_c) > {1'b0, hp}) && (c1 + (CNT_W+1)'(s_c) > {1'b0, wp});
    in_plane = (r_q >= b_ext) && (r_q < b_ext + h_c) && (c_q >= b_ext) &&
               (c_q < b_ext + w_c);
    v0     = in_plane ? s_axis_tdata_i : '0;

    // raster advance
    r_d  = r_q;
    c_d  = c_q;
    rs_d = rs_q;
    for (int m = 1; m <= STEP_MAX; m++) begin
      res_r_d[m] = res_r_q[m];
      res_c_d[m] = (res_c_q[m] == RES_W'(m - 1)) ? '0 : res_c_q[m] + RES_W'(1);
    end
    if (c1 >= {1'b0, wp}) begin
      c_d = '0;
      for (int m = 1; m <= STEP_MAX; m++) res_c_d[m] = '0;
      if (r1 >= {1'b0, hp}) begin
        r_d  = '0;
        rs_d = '0;
        for (int m = 1; m <= STEP_MAX; m++) res_r_d[m] = '0;
      end else begin
        r_d  = r1[CNT_W-1:0];
        rs_d = (rs_q == SLOT_W'(LINE_ROWS - 1)) ? '0 : rs_q + SLOT_W'(1);
        for (int m = 1; m <= STEP_MAX; m++) begin
          res_r_d[m] = (res_r_q[m] == RES_W'(m - 1)) ? '0 : res_r_q[m] + RES_W'(1);
        end
      end
    end else begin
      c_d = c1[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q  <= '0;
      c_q  <= '0;
      rs_q <= '0;
      for (int m = 1; m <= STEP_MAX; m++) begin
        res_r_q[m] <= '0;
        res_c_q[m] <= '0;
      end
    end else if (in_fire) begin
      r_q  <= r_d;
      c_q  <= c_d;
      rs_q <= rs_d;
      for (int m = 1; m <= STEP_MAX; m++) begin
        res_r_q[m] <= res_r_d[m];
        res_c_q[m] <= res_c_d[m];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 registers: sample, its slot and column, window flags
  logic [VALUE_BITS-1:0] v1_q;
  logic [SLOT_W-1:0]     rs1_q;
  logic [ADDR_W-1:0]     col1_q;
  logic                  fwd_q;
  logic [SLOT_W-1:0]     fwd_slot_q;
  logic [VALUE_BITS-1:0] fwd_val_q;
  logic [ADDR_W-1:0]     rd_addr;

  assign rd_addr = c_q[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
      // same column written by the item leaving stage 1: bypass the memory
      fwd_q      <= s1_fire && (col1_q == rd_addr);
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      v1_q       <= v0;
      rs1_q      <= rs_q;
      col1_q     <= rd_addr;
      emit1_q    <= emit0;
      done1_q    <= done0;
      fwd_slot_q <= rs1_q;
      fwd_val_q  <= v1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Line memory: one bank per stored row, cleared after reset
  logic                  clr_last;
  logic [ADDR_W-1:0]     clr_q;
  logic [LINE_ROWS-1:0]  mem_we;
  logic [ADDR_W-1:0]     mem_wa;
  logic [VALUE_BITS-1:0] mem_wd;
  logic [VALUE_BITS-1:0] rd_data [LINE_ROWS];

  assign clr_last = (clr_q == ADDR_W'(LINE_LEN - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clearing_q <= !clr_last;
      clr_q      <= clr_q + ADDR_W'(1);
    end
  end

  always_comb begin
    for (int g = 0; g < LINE_ROWS; g++) begin
      mem_we[g] = clearing_q || (s1_fire && (rs1_q == SLOT_W'(g)));
    end
    mem_wa = clearing_q ? clr_q : col1_q;
    mem_wd = clearing_q ? '0 : v1_q;
  end

  for (genvar g = 0; g < LINE_ROWS; g++) begin : g_bank
    logic [VALUE_BITS-1:0] mem [LINE_LEN];
    logic [VALUE_BITS-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (mem_we[g]) mem[mem_wa] <= mem_wd;
      if (in_fire)   rd_q <= mem[rd_addr];
    end
    assign rd_data[g] = rd_q;
  end

  // Column entering the window: stored rows oldest first, then the new sample
  logic [VALUE_BITS-1:0] row_val [LINE_ROWS];
  logic [VALUE_BITS-1:0] colv    [MAX_POOL];
  logic [SLOT_W:0]       slot;

  always_comb begin
    for (int g = 0; g < LINE_ROWS; g++) begin
      row_val[g] = (fwd_q && (fwd_slot_q == SLOT_W'(g))) ? fwd_val_q : rd_data[g];
    end
    for (int k = 0; k < LINE_ROWS; k++) begin
      slot = (SLOT_W+1)'(rs1_q) + (SLOT_W+1)'(k);
      if (slot >= (SLOT_W+1)'(LINE_ROWS)) slot = slot - (SLOT_W+1)'(LINE_ROWS);
      colv[k] = row_val[slot[SLOT_W-1:0]];
    end
    colv[MAX_POOL-1] = v1_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: shift window
  logic [VALUE_BITS-1:0] win_q [MAX_POOL][MAX_POOL];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_POOL; k++) begin
        for (int m = 0; m < MAX_POOL; m++) win_q[k][m] <= '0;
      end
      emit2_q <= 1'b0;
    end else if (s1_fire) begin
      for (int k = 0; k < MAX_POOL; k++) begin
        for (int m = 0; m < MAX_POOL - 1; m++) win_q[k][m] <= win_q[k][m+1];
        win_q[k][MAX_POOL-1] <= colv[k];
      end
      emit2_q <= emit1_q;
    end else if (s2_fire) begin
      emit2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) done2_q <= done1_q;
  end

  // Compare tree: row-major leaves, a later leaf wins only when strictly greater
  tree_node_t        nd [2*TREE_LEAF-1];
  tree_node_t        na, nb;
  logic [PC_W-1:0]   lo_r, lo_c;
  logic [PROD_W-1:0] pos_full;

  always_comb begin
    lo_r = PC_W'(MAX_POOL) - ph_c;
    lo_c = PC_W'(MAX_POOL) - pw_c;
    for (int i = 0; i < TREE_LEAF; i++) begin
      nd[TREE_LEAF-1+i] = '0;
    end
    for (int k = 0; k < MAX_POOL; k++) begin
      for (int m = 0; m < MAX_POOL; m++) begin
        nd[TREE_LEAF-1+k*MAX_POOL+m].vld = (PC_W'(k) >= lo_r) && (PC_W'(m) >= lo_c);
        nd[TREE_LEAF-1+k*MAX_POOL+m].val = win_q[k][m];
        nd[TREE_LEAF-1+k*MAX_POOL+m].row = PI_W'(k);
        nd[TREE_LEAF-1+k*MAX_POOL+m].col = PI_W'(m);
      end
    end
    for (int n = TREE_LEAF - 2; n >= 0; n--) begin
      na = nd[2*n+1];
      nb = nd[2*n+2];
      nd[n] = (!na.vld || (nb.vld && ($signed(nb.val) > $signed(na.val)))) ? nb : na;
    end
    na = nd[0];
    nb = nd[0];
    pos_full = (PROD_W'(na.row) - PROD_W'(lo_r)) * PROD_W'(pw_c) +
               (PROD_W'(nb.col) - PROD_W'(lo_c));
  end

  // ---------------------------------------------------------------------------
  // Output register
  logic [VALUE_BITS-1:0] out_max_q;
  logic [POS_W-1:0]      out_pos_q;
  logic                  out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      out_max_q  <= nd[0].val;
      out_pos_q  <= pos_full[POS_W-1:0];
      out_last_q <= done2_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_W-VALUE_BITS-POS_W)'(0), out_pos_q, out_max_q};
  assign m_axis_tlast_o  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !s1_valid_q)
    else $error("line memory write while clearing");

  a_s1_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q)
    else $error("accepted pixel not held in stage 1");

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(emit2_q) |-> $past(s1_fire && emit1_q))
    else $error("window result without a closing pixel");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (c_q < CNT_W'(LINE_LEN)) && (rs_q < SLOT_W'(LINE_ROWS)))
    else $error("column or slot counter out of range");

endmodule
